// ===== design/running_median_two_heaps_macros.svh =====
// Assertion macros for the running median block.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RMTH_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("running median assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RMTH_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("running median assertion failed");
`else
`define RMTH_ASSERT_IMP(label, clk, rst_n, a, b)
`define RMTH_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== design/rmth_pkg.sv =====
// Shared types and constants of the running median block.
package rmth_pkg;
	localparam int HEAP_DEPTH_DEF = 512;
	localparam int VALUE_W = 31;
	localparam int MEDIAN_W = 32;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DECIDE, OP_PUSH_INIT, OP_PUSH_CHECK, OP_PUSH_WAIT,
		OP_POP_INIT, OP_POP_LAST, OP_POP_CHECK, OP_POP_C1, OP_POP_C2, OP_POP_MOVE,
		OP_SWAP, OP_UPDATE, OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_PUSH_INIT, ST_PUSH_CHECK, ST_PUSH_WAIT,
		ST_POP_INIT, ST_POP_LAST, ST_POP_CHECK, ST_POP_C1, ST_POP_C2, ST_POP_MOVE,
		ST_SWAP, ST_UPDATE, ST_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic equal;
		logic i_zero;
		logic push_above;
		logic pop_one;
		logic c_ge_n;
		logic c2_lt_n;
		logic move_above;
		logic rebalance;
		logic balanced;
		logic out_free;
	} sts_t;
endpackage

// ===== design/rmth_dp.sv =====
// Datapath of the running median block: heap memories, counters and result register.
module rmth_dp import rmth_pkg::*; #(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [MEDIAN_W-1:0] median_x2,
	output logic                status
);
	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = AW + 2;

	logic [VALUE_W-1:0] low_mem [HEAP_DEPTH];
	logic [VALUE_W-1:0] high_mem [HEAP_DEPTH];
	logic [VALUE_W-1:0] lo_rd_q, hi_rd_q, rdata;
	logic [VALUE_W-1:0] cur_q, last_q, cand_q, low_root_q, high_root_q, root_sel;
	logic [AW-1:0] i_q, cidx_q, parent, raddr, waddr;
	logic [CW-1:0] n_q, low_cnt_q, high_cnt_q, cnt_sel;
	logic [XW-1:0] c_x, n_x;
	logic [MEDIAN_W-1:0] median_q, v2;
	logic sel_q, rej_q, eq_q, we, lt, gt, d_sel, c2_above;
	logic [VALUE_W-1:0] wdata;
	logic [CW:0] lo_w, hi_w;

	// A belongs above b: greater for the max heap, smaller for the min heap.
	function automatic logic above(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
			input logic is_min);
		above = is_min ? (a < b) : (a > b);
	endfunction

	// Index arithmetic and decision logic.
	assign rdata    = sel_q ? hi_rd_q : lo_rd_q;
	assign cnt_sel  = sel_q ? high_cnt_q : low_cnt_q;
	assign root_sel = sel_q ? high_root_q : low_root_q;
	assign parent   = (i_q - AW'(1)) >> 1;
	assign c_x      = (XW'(i_q) << 1) + XW'(1);
	assign n_x      = XW'(n_q);
	assign v2       = {cur_q, 1'b0};
	assign lt       = v2 < median_q;
	assign gt       = v2 > median_q;
	assign d_sel    = lt ? 1'b0 : (gt ? 1'b1 : (low_cnt_q > high_cnt_q));
	assign lo_w     = {1'b0, low_cnt_q};
	assign hi_w     = {1'b0, high_cnt_q};
	assign c2_above = above(rdata, cand_q, sel_q);

	always_comb begin
		sts.reject     = (d_sel ? high_cnt_q : low_cnt_q) >= CW'(HEAP_DEPTH);
		sts.equal      = eq_q;
		sts.i_zero     = (i_q == '0);
		sts.push_above = above(cur_q, rdata, sel_q);
		sts.pop_one    = (cnt_sel == CW'(1));
		sts.c_ge_n     = (c_x >= n_x);
		sts.c2_lt_n    = ((c_x + XW'(1)) < n_x);
		sts.move_above = above(cand_q, last_q, sel_q);
		sts.rebalance  = sel_q ? (hi_w > lo_w + (CW+1)'(1)) : (lo_w > hi_w + (CW+1)'(1));
		sts.balanced   = (lo_w <= hi_w + (CW+1)'(1)) && (hi_w <= lo_w + (CW+1)'(1));
		sts.out_free   = !out_valid || !out_stall;
	end

	// Memory addresses and write data for each command.
	always_comb begin
		we = 1'b0;
		waddr = i_q;
		wdata = cur_q;
		raddr = '0;
		unique case (cmd.op)
			OP_PUSH_CHECK: begin
				if (i_q == '0) we = 1'b1;
				else raddr = parent;
			end
			OP_PUSH_WAIT: begin
				we = 1'b1;
				wdata = sts.push_above ? rdata : cur_q;
			end
			OP_POP_INIT: raddr = AW'(cnt_sel - CW'(1));
			OP_POP_CHECK: begin
				if (sts.c_ge_n) begin
					we = 1'b1;
					wdata = last_q;
				end else begin
					raddr = c_x[AW-1:0];
				end
			end
			OP_POP_C1: raddr = AW'(c_x + XW'(1));
			OP_POP_MOVE: begin
				we = 1'b1;
				wdata = sts.move_above ? cand_q : last_q;
			end
			default: ;
		endcase
	end

	// Heap memories with registered read data.
	always_ff @(posedge clk) begin
		if (we && !sel_q) low_mem[waddr] <= wdata;
		if (we && sel_q) high_mem[waddr] <= wdata;
		lo_rd_q <= low_mem[raddr];
		hi_rd_q <= high_mem[raddr];
	end

	// Control registers: counts, median and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cnt_q <= '0;
			high_cnt_q <= '0;
			median_q <= '0;
			out_valid <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (cmd.op)
				OP_DECIDE: sel_q <= d_sel;
				OP_SWAP:   sel_q <= ~sel_q;
				OP_PUSH_INIT: begin
					if (sel_q) high_cnt_q <= high_cnt_q + CW'(1);
					else low_cnt_q <= low_cnt_q + CW'(1);
				end
				OP_POP_INIT: begin
					if (sel_q) high_cnt_q <= high_cnt_q - CW'(1);
					else low_cnt_q <= low_cnt_q - CW'(1);
				end
				OP_UPDATE: begin
					if (low_cnt_q == high_cnt_q)
						median_q <= MEDIAN_W'(low_root_q) + MEDIAN_W'(high_root_q);
					else if (low_cnt_q > high_cnt_q)
						median_q <= {low_root_q, 1'b0};
					else
						median_q <= {high_root_q, 1'b0};
				end
				default: ;
			endcase
		end
	end

	// Working registers of the heap walks and the result payload.
	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			if (sel_q) high_root_q <= wdata;
			else low_root_q <= wdata;
		end
		case (cmd.op)
			OP_LOAD: cur_q <= value;
			OP_DECIDE: begin
				rej_q <= sts.reject;
				eq_q <= !lt && !gt;
			end
			OP_PUSH_INIT: i_q <= cnt_sel[AW-1:0];
			OP_PUSH_WAIT: if (sts.push_above) i_q <= parent;
			OP_POP_INIT: begin
				cur_q <= root_sel;
				n_q <= cnt_sel - CW'(1);
			end
			OP_POP_LAST: begin
				last_q <= rdata;
				i_q <= '0;
			end
			OP_POP_C1: begin
				cand_q <= rdata;
				cidx_q <= c_x[AW-1:0];
			end
			OP_POP_C2: if (c2_above) begin
				cand_q <= rdata;
				cidx_q <= cidx_q + AW'(1);
			end
			OP_POP_MOVE: if (sts.move_above) i_q <= cidx_q;
			OP_OUT: begin
				median_x2 <= median_q;
				status <= rej_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== design/rmth_ctrl.sv =====
// Controller state machine of the running median block.
module rmth_ctrl import rmth_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_nx;
	logic second_q;

	// State register and the flag for the rebalancing insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DECIDE) second_q <= 1'b0;
			else if (state_q == ST_SWAP) second_q <= 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_nx = ST_DECIDE;
			ST_DECIDE:     state_nx = sts.reject ? ST_OUT : ST_PUSH_INIT;
			ST_PUSH_INIT:  state_nx = ST_PUSH_CHECK;
			ST_PUSH_CHECK: begin
				if (!sts.i_zero) state_nx = ST_PUSH_WAIT;
				else if (second_q) state_nx = ST_UPDATE;
				else if (sts.equal) state_nx = ST_OUT;
				else if (sts.rebalance) state_nx = ST_POP_INIT;
				else state_nx = ST_UPDATE;
			end
			ST_PUSH_WAIT: begin
				if (sts.push_above) state_nx = ST_PUSH_CHECK;
				else if (second_q) state_nx = ST_UPDATE;
				else if (sts.equal) state_nx = ST_OUT;
				else if (sts.rebalance) state_nx = ST_POP_INIT;
				else state_nx = ST_UPDATE;
			end
			ST_POP_INIT:   state_nx = sts.pop_one ? ST_SWAP : ST_POP_LAST;
			ST_POP_LAST:   state_nx = ST_POP_CHECK;
			ST_POP_CHECK:  state_nx = sts.c_ge_n ? ST_SWAP : ST_POP_C1;
			ST_POP_C1:     state_nx = sts.c2_lt_n ? ST_POP_C2 : ST_POP_MOVE;
			ST_POP_C2:     state_nx = ST_POP_MOVE;
			ST_POP_MOVE:   state_nx = sts.move_above ? ST_POP_CHECK : ST_SWAP;
			ST_SWAP:       state_nx = ST_PUSH_INIT;
			ST_UPDATE:     state_nx = ST_OUT;
			ST_OUT:        if (sts.out_free) state_nx = ST_IDLE;
			default:       state_nx = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE:       if (in_valid) cmd.op = OP_LOAD;
			ST_DECIDE:     cmd.op = OP_DECIDE;
			ST_PUSH_INIT:  cmd.op = OP_PUSH_INIT;
			ST_PUSH_CHECK: cmd.op = OP_PUSH_CHECK;
			ST_PUSH_WAIT:  cmd.op = OP_PUSH_WAIT;
			ST_POP_INIT:   cmd.op = OP_POP_INIT;
			ST_POP_LAST:   cmd.op = OP_POP_LAST;
			ST_POP_CHECK:  cmd.op = OP_POP_CHECK;
			ST_POP_C1:     cmd.op = OP_POP_C1;
			ST_POP_C2:     cmd.op = OP_POP_C2;
			ST_POP_MOVE:   cmd.op = OP_POP_MOVE;
			ST_SWAP:       cmd.op = OP_SWAP;
			ST_UPDATE:     cmd.op = OP_UPDATE;
			ST_OUT:        if (sts.out_free) cmd.op = OP_OUT;
			default:       cmd.op = OP_NONE;
		endcase
	end
endmodule

// ===== design/running_median_two_heaps.sv =====
// Top level of the running median block: controller, datapath and checks.
// Usage:
// The input channel (in_valid, in_stall, value) carries one nonnegative
// observation per transfer. The output channel (out_valid, out_stall,
// median_x2, status) returns exactly one result per input transfer, in order:
// twice the running median and a status bit that is set when the heap that
// would receive the value is full, in which case nothing changes.
// One item is worked on at a time; in_stall is high while it is in progress.
// Each heap walk visits about log2(HEAP_DEPTH) levels: an insert does one memory
// read and compare per level, a removal of the root up to two reads and compares per level.
// The result sits in an output register; a stalled result is held and the
// next item waits only until that register can be reloaded.
// Reset clears both heap counts, the median (to zero) and the result valid.
// Heap memory contents are left as they are; no entry is read before written.
module running_median_two_heaps import rmth_pkg::*; #(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [MEDIAN_W-1:0] median_x2,
	output logic                status
);
`include "running_median_two_heaps_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	rmth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Heaps and arithmetic.
	rmth_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median_x2 (median_x2),
		.status    (status)
	);

	// An accepted item keeps the block busy in the following cycle.
	`RMTH_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// A result is loaded only when the output register is free.
	`RMTH_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.op == OP_OUT, sts.out_free)
	// Between items the heap sizes differ by at most one.
	`RMTH_ASSERT_IMP(a_balanced_idle, clk, arst_n, cmd.op == OP_LOAD, sts.balanced)
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-heap running median block.
module testbench;
	import rmth_pkg::*;

	localparam int DEPTH      = HEAP_DEPTH_DEF;
	localparam int RAND_ITEMS = 1100;
	localparam int QUIET_LO   = 300;
	localparam int QUIET_HI   = 500;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 400;
	localparam int PAUSE_AT   = 700;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct {
		logic [MEDIAN_W-1:0] median;
		logic                rejected;
	} median_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_stall;
	logic [MEDIAN_W-1:0] median_x2;
	logic                status;

	logic [VALUE_W-1:0]  pending_values[$];
	median_result_t      awaited_results[$];
	int                  sent_count;
	int                  error_count;
	int                  cycle_count;
	bit                  in_took;
	bit                  hold_done;
	int                  hold_left;

	// Predictor state: both heaps, their counts and the doubled median.
	logic [VALUE_W-1:0]  lower_heap[DEPTH];
	logic [VALUE_W-1:0]  upper_heap[DEPTH];
	int                  lower_n;
	int                  upper_n;
	logic [MEDIAN_W-1:0] twice_median;

	running_median_two_heaps dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median_x2 (median_x2),
		.status    (status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Ordering test: a above b in a max heap or a min heap.
	function automatic bit ranks_above(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
			bit is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

	// Sift a value up from the end of the chosen heap.
	function automatic void heap_insert(bit to_lower, logic [VALUE_W-1:0] v);
		int i;
		int p;
		i = to_lower ? lower_n : upper_n;
		if (to_lower) lower_n++; else upper_n++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (to_lower) begin
				if (!ranks_above(v, lower_heap[p], 1'b1)) break;
				lower_heap[i] = lower_heap[p];
			end else begin
				if (!ranks_above(v, upper_heap[p], 1'b0)) break;
				upper_heap[i] = upper_heap[p];
			end
			i = p;
		end
		if (to_lower) lower_heap[i] = v; else upper_heap[i] = v;
	endfunction

	// Remove the root of the chosen heap and sift the last entry down.
	function automatic logic [VALUE_W-1:0] heap_take_root(bit from_lower);
		logic [VALUE_W-1:0] top;
		logic [VALUE_W-1:0] last;
		int n;
		int i;
		int c;
		top = from_lower ? lower_heap[0] : upper_heap[0];
		n = (from_lower ? lower_n : upper_n) - 1;
		if (from_lower) lower_n = n; else upper_n = n;
		if (n == 0) return top;
		last = from_lower ? lower_heap[n] : upper_heap[n];
		i = 0;
		forever begin
			c = 2 * i + 1;
			if (c >= n) break;
			if (from_lower) begin
				if (c + 1 < n && lower_heap[c + 1] > lower_heap[c]) c++;
				if (!(lower_heap[c] > last)) break;
				lower_heap[i] = lower_heap[c];
			end else begin
				if (c + 1 < n && upper_heap[c + 1] < upper_heap[c]) c++;
				if (!(upper_heap[c] < last)) break;
				upper_heap[i] = upper_heap[c];
			end
			i = c;
		end
		if (from_lower) lower_heap[i] = last; else upper_heap[i] = last;
		return top;
	endfunction

	function automatic void refresh_median();
		if (lower_n == upper_n)
			twice_median = {1'b0, lower_heap[0]} + {1'b0, upper_heap[0]};
		else if (lower_n > upper_n)
			twice_median = {lower_heap[0], 1'b0};
		else
			twice_median = {upper_heap[0], 1'b0};
	endfunction

	// Work out the result of one observation and update the predictor state.
	function automatic median_result_t predict_median(logic [VALUE_W-1:0] v);
		median_result_t r;
		logic [MEDIAN_W:0] v2;
		r.rejected = 1'b0;
		v2 = {1'b0, v, 1'b0};
		if (v2 < {1'b0, twice_median}) begin
			if (lower_n >= DEPTH) begin
				r.rejected = 1'b1;
			end else begin
				heap_insert(1'b1, v);
				if (lower_n > upper_n + 1) heap_insert(1'b0, heap_take_root(1'b1));
				refresh_median();
			end
		end else if (v2 > {1'b0, twice_median}) begin
			if (upper_n >= DEPTH) begin
				r.rejected = 1'b1;
			end else begin
				heap_insert(1'b0, v);
				if (upper_n > lower_n + 1) heap_insert(1'b1, heap_take_root(1'b0));
				refresh_median();
			end
		end else if (lower_n > upper_n) begin
			if (upper_n >= DEPTH) r.rejected = 1'b1;
			else heap_insert(1'b0, v);
		end else begin
			if (lower_n >= DEPTH) r.rejected = 1'b1;
			else heap_insert(1'b1, v);
		end
		r.median = twice_median;
		return r;
	endfunction

	// Monitor: predict on each input transfer, check each output transfer.
	always @(posedge clk) begin
		median_result_t want;
		cycle_count <= cycle_count + 1;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			awaited_results.push_back(predict_median(value));
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none expected: median_x2 %0d status %0d",
					$time, median_x2, status);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (median_x2 !== want.median) begin
					$display("%0t: median_x2 expected %0d actual %0d",
						$time, want.median, median_x2);
					error_count++;
				end
				if (status !== want.rejected) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.rejected, status);
					error_count++;
				end
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Driver: present the next pending value once the previous transfer is done.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_values.size() == 0 ||
					(sent_count == PAUSE_AT && awaited_results.size() != 0) ||
					((sent_count < QUIET_LO || sent_count > QUIET_HI) &&
					$urandom_range(99) < 16)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				value <= pending_values.pop_front();
				sent_count <= sent_count + 1;
			end
		end
	end

	// Receiver: random stalls outside the quiet stretch, one long hold-off inside it.
	always @(negedge clk) begin
		if (!hold_done && sent_count == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (sent_count >= QUIET_LO && sent_count <= QUIET_HI) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 16);
		end
	end

	initial begin
		int r;
		in_valid = 1'b0;
		value = '0;
		out_stall = 1'b0;
		in_took = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		sent_count = 0;
		error_count = 0;
		cycle_count = 0;
		lower_n = 0;
		upper_n = 0;
		twice_median = '0;
		arst_n = 1'b0;

		// Directed values: equal to the zero median, extremes, repeats, halves.
		pending_values.push_back('0);
		pending_values.push_back('0);
		pending_values.push_back({VALUE_W{1'b1}});
		pending_values.push_back({VALUE_W{1'b1}});
		pending_values.push_back({VALUE_W{1'b1}});
		pending_values.push_back(31'd1);
		pending_values.push_back(31'd5);
		pending_values.push_back(31'd5);
		pending_values.push_back(31'd5);
		pending_values.push_back(31'd4);
		pending_values.push_back(31'd6);
		pending_values.push_back(31'h4000_0000);
		pending_values.push_back(31'h3FFF_FFFF);
		pending_values.push_back(31'h2AAA_AAAA);
		pending_values.push_back(31'h5555_5555);
		pending_values.push_back('0);
		pending_values.push_back(31'd3);
		pending_values.push_back(31'd2);

		// Random values; enough in total to fill both heaps and hit rejection.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				pending_values.push_back(VALUE_W'($urandom_range(63)));
			else if (r < 85)
				pending_values.push_back(VALUE_W'($urandom));
			else
				pending_values.push_back(31'd32);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_values.size() == 0 && in_took);
		wait (awaited_results.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
